// ===== rtl/core/pwu_pkg.sv =====
// Shared types, constants and helper functions for the particle weight update block.
package pwu_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int LM_AW = $clog2(MAX_LANDMARKS);
    localparam int LM_CW = $clog2(MAX_LANDMARKS + 1);
    localparam int CORDIC_STEPS = 17;
    localparam int ZW = 20;
    localparam int XW = 33;

    localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30 = 33'sd1073741824;
    localparam logic [39:0] COST_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_POSE = 2'd1;
    localparam logic [1:0] CMD_OBS = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_INV_X = 2'd0;
    localparam logic [1:0] REG_INV_Y = 2'd1;
    localparam logic [1:0] REG_LM_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [LM_AW-1:0] slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [15:0] heading;
        logic final_obs;
    } pwu_in_t;

    typedef struct packed {
        logic [LM_AW-1:0] match_slot;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic [39:0] cost_sum;
        logic [7:0] obs_count;
        logic particle_done;
    } pwu_out_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } pwu_cord_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0: a = 20'sd51472;
            5'd1: a = 20'sd30385;
            5'd2: a = 20'sd16055;
            5'd3: a = 20'sd8150;
            5'd4: a = 20'sd4091;
            5'd5: a = 20'sd2047;
            5'd6: a = 20'sd1024;
            5'd7: a = 20'sd512;
            5'd8: a = 20'sd256;
            5'd9: a = 20'sd128;
            5'd10: a = 20'sd64;
            5'd11: a = 20'sd32;
            5'd12: a = 20'sd16;
            5'd13: a = 20'sd8;
            5'd14: a = 20'sd4;
            5'd15: a = 20'sd2;
            5'd16: a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/pwu_cordic_cell.sv =====
// One registered CORDIC rotation step of the sine and cosine chain.
module pwu_cordic_cell
    import pwu_pkg::*;
(
    input  logic      clk,
    input  logic [4:0] step,
    input  pwu_cord_t in_d,
    output pwu_cord_t out_d
);

    pwu_cord_t out_reg;
    pwu_cord_t out_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        xs = $signed(in_d.x) >>> step;
        ys = $signed(in_d.y) >>> step;
        if (!in_d.z[ZW-1])
        begin
            out_next.x = in_d.x - ys;
            out_next.y = in_d.y + xs;
            out_next.z = in_d.z - atan_q16(step);
        end
        else
        begin
            out_next.x = in_d.x + ys;
            out_next.y = in_d.y - xs;
            out_next.z = in_d.z + atan_q16(step);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_d = out_reg;

endmodule

// ===== rtl/core/pwu_cordic_chain.sv =====
// Row of CORDIC cells that turns a reduced angle into sine and cosine.
module pwu_cordic_chain
    import pwu_pkg::*;
(
    input  logic                 clk,
    input  logic signed [ZW-1:0] angle,
    output pwu_cord_t            result
);

    pwu_cord_t link [CORDIC_STEPS+1];

    assign link[0].x = CORDIC_GAIN_Q30;
    assign link[0].y = '0;
    assign link[0].z = angle;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        pwu_cordic_cell u_cell (
            .clk   (clk),
            .step  (5'(g)),
            .in_d  (link[g]),
            .out_d (link[g+1])
        );
    end

    assign result = link[CORDIC_STEPS];

endmodule

// ===== rtl/core/particle_weight_update.sv =====
// Top level of the particle weight update: landmark table, pose, matching and cost.
// A landmark load or a pose word leaves busy low. After an observation is accepted,
// busy stays high while the block waits on the CORDIC cell row for sine and cosine,
// uses the shared multiplier for the rotation, forms the world position, runs the
// nearest-landmark scan that reads one table entry per cycle over landmark_count
// entries (taken between 1 and 64), then uses the shared multiplier for the cost.
// The result word is shown for one cycle on result with result_valid, in the first
// cycle with busy low; the receiver cannot stall it. Configuration is always ready;
// the user must write it while busy is low, which the block does not enforce.
module particle_weight_update
    import pwu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pwu_in_t     item,
    output logic        result_valid,
    output pwu_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CORD, S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_WORLD, S_SCAN,
        S_COST0, S_COST1, S_COST2, S_COST3
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] inv_x_reg, inv_y_reg;
    logic [LM_CW-1:0] lm_count_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic signed [15:0] pose_head_reg;
    logic [39:0] cost_reg, cost_next;
    logic [7:0] count_reg, count_next;
    pwu_in_t obs_reg;

    logic signed [31:0] lm_x_mem [MAX_LANDMARKS];
    logic signed [31:0] lm_y_mem [MAX_LANDMARKS];
    logic signed [31:0] rd_x_reg, rd_y_reg;

    logic [4:0] wait_reg, wait_next;
    logic signed [31:0] cos_reg, sin_reg, cos_next, sin_next;
    logic signed [63:0] acc_x_reg, acc_y_reg, acc_x_next, acc_y_next;
    logic signed [31:0] wx_reg, wy_reg, wx_next, wy_next;

    logic [LM_CW-1:0] issue_reg, issue_next, n_eff;
    logic v1_reg, v2_reg, v3_reg, v1_next;
    logic [LM_AW-1:0] i1_reg, i2_reg, i3_reg;
    logic [31:0] dxa_reg, dya_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic [64:0] best_sum_reg;
    logic [63:0] best_sqx_reg, best_sqy_reg;
    logic [LM_AW-1:0] best_idx_reg;
    logic [64:0] cur_sum;
    logic best_take;

    logic [64:0] t_reg, t_next;
    logic signed [XW-1:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic result_valid_reg, result_valid_next;
    pwu_out_t result_reg, result_next;

    logic signed [ZW-1:0] z_head, z_init;
    logic neg_sc;
    pwu_cord_t cord_out;
    logic accept;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sc(input logic signed [XW-1:0] v,
                                                    input logic neg);
        logic signed [XW-1:0] c;
        if (v > ONE_Q30)
            c = ONE_Q30;
        else if (v < -ONE_Q30)
            c = -ONE_Q30;
        else
            c = v;
        if (neg)
            c = -c;
        return c[31:0];
    endfunction

    function automatic logic [39:0] add_sat(input logic [39:0] a, input logic [64:0] t);
        logic [39:0] ts;
        logic [40:0] s;
        ts = (t > {25'd0, COST_MAX}) ? COST_MAX : t[39:0];
        s = {1'b0, a} + {1'b0, ts};
        return s[40] ? COST_MAX : s[39:0];
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assign z_head = ZW'($signed({pose_head_reg, 3'b000}));
    always_comb
    begin
        neg_sc = 1'b0;
        z_init = z_head;
        if (z_head > HALF_PI_Q16)
        begin
            z_init = z_head - PI_Q16;
            neg_sc = 1'b1;
        end
        else if (z_head < -HALF_PI_Q16)
        begin
            z_init = z_head + PI_Q16;
            neg_sc = 1'b1;
        end
    end

    pwu_cordic_chain u_chain (
        .clk    (clk),
        .angle  (z_init),
        .result (cord_out)
    );

    always_comb
    begin
        if (lm_count_reg == '0)
            n_eff = LM_CW'(1);
        else if (lm_count_reg > LM_CW'(MAX_LANDMARKS))
            n_eff = LM_CW'(MAX_LANDMARKS);
        else
            n_eff = lm_count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.command == CMD_LOAD)
        begin
            lm_x_mem[item.slot] <= item.coord_x;
            lm_y_mem[item.slot] <= item.coord_y;
        end
        rd_x_reg <= lm_x_mem[issue_reg[LM_AW-1:0]];
        rd_y_reg <= lm_y_mem[issue_reg[LM_AW-1:0]];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ROT0:
            begin
                mul_a = XW'(obs_reg.coord_x);
                mul_b = XW'(cos_reg);
            end
            S_ROT1:
            begin
                mul_a = XW'(obs_reg.coord_y);
                mul_b = XW'(sin_reg);
            end
            S_ROT2:
            begin
                mul_a = XW'(obs_reg.coord_x);
                mul_b = XW'(sin_reg);
            end
            S_ROT3:
            begin
                mul_a = XW'(obs_reg.coord_y);
                mul_b = XW'(cos_reg);
            end
            S_COST0:
            begin
                mul_a = $signed({1'b0, best_sqx_reg[63:32]});
                mul_b = $signed({1'b0, inv_x_reg});
            end
            S_COST1:
            begin
                mul_a = $signed({1'b0, best_sqx_reg[31:0]});
                mul_b = $signed({1'b0, inv_x_reg});
            end
            S_COST2:
            begin
                mul_a = $signed({1'b0, best_sqy_reg[63:32]});
                mul_b = $signed({1'b0, inv_y_reg});
            end
            S_COST3:
            begin
                mul_a = $signed({1'b0, best_sqy_reg[31:0]});
                mul_b = $signed({1'b0, inv_y_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign cur_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign best_take = (i3_reg == '0) || (cur_sum < best_sum_reg);

    always_ff @(posedge clk)
    begin
        v2_reg <= v1_reg;
        i2_reg <= i1_reg;
        v3_reg <= v2_reg;
        i3_reg <= i2_reg;
        dxa_reg <= 32'(($signed({wx_reg[31], wx_reg}) - $signed({rd_x_reg[31], rd_x_reg})) < 0
            ? -($signed({wx_reg[31], wx_reg}) - $signed({rd_x_reg[31], rd_x_reg}))
            : ($signed({wx_reg[31], wx_reg}) - $signed({rd_x_reg[31], rd_x_reg})));
        dya_reg <= 32'(($signed({wy_reg[31], wy_reg}) - $signed({rd_y_reg[31], rd_y_reg})) < 0
            ? -($signed({wy_reg[31], wy_reg}) - $signed({rd_y_reg[31], rd_y_reg}))
            : ($signed({wy_reg[31], wy_reg}) - $signed({rd_y_reg[31], rd_y_reg})));
        sqx_reg <= {32'd0, dxa_reg} * {32'd0, dxa_reg};
        sqy_reg <= {32'd0, dya_reg} * {32'd0, dya_reg};
        if (v3_reg && best_take)
        begin
            best_sum_reg <= cur_sum;
            best_sqx_reg <= sqx_reg;
            best_sqy_reg <= sqy_reg;
            best_idx_reg <= i3_reg;
        end
        i1_reg <= issue_reg[LM_AW-1:0];
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;
        t_reg <= t_next;
        result_reg <= result_next;
        if (accept)
        begin
            obs_reg <= item;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        issue_next = issue_reg;
        v1_next = 1'b0;
        cos_next = cos_reg;
        sin_next = sin_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        wx_next = wx_reg;
        wy_next = wy_reg;
        t_next = t_reg;
        cost_next = cost_reg;
        count_next = count_reg;
        result_valid_next = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.command == CMD_POSE)
                begin
                    cost_next = '0;
                    count_next = '0;
                end
                else if (accept && item.command == CMD_OBS)
                begin
                    wait_next = '0;
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                wait_next = wait_reg + 5'd1;
                if (wait_reg == 5'(CORDIC_STEPS))
                begin
                    cos_next = clamp_sc(cord_out.x, neg_sc);
                    sin_next = clamp_sc(cord_out.y, neg_sc);
                    state_next = S_ROT0;
                end
            end
            S_ROT0:
            begin
                acc_x_next = mul_p[63:0];
                state_next = S_ROT1;
            end
            S_ROT1:
            begin
                acc_x_next = acc_x_reg - mul_p[63:0];
                state_next = S_ROT2;
            end
            S_ROT2:
            begin
                acc_y_next = mul_p[63:0];
                state_next = S_ROT3;
            end
            S_ROT3:
            begin
                acc_y_next = acc_y_reg + mul_p[63:0];
                state_next = S_WORLD;
            end
            S_WORLD:
            begin
                wx_next = sat32(64'($signed(pose_x_reg))
                    + ((acc_x_reg + 64'sd536870912) >>> 30));
                wy_next = sat32(64'($signed(pose_y_reg))
                    + ((acc_y_reg + 64'sd536870912) >>> 30));
                issue_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (issue_reg < n_eff)
                begin
                    v1_next = 1'b1;
                    issue_next = issue_reg + LM_CW'(1);
                end
                if (v3_reg && ({1'b0, i3_reg} == n_eff - LM_CW'(1)))
                begin
                    state_next = S_COST0;
                end
            end
            S_COST0:
            begin
                t_next = {1'b0, mul_p[63:0]};
                state_next = S_COST1;
            end
            S_COST1:
            begin
                cost_next = add_sat(cost_reg, t_reg + {33'd0, mul_p[63:32]});
                state_next = S_COST2;
            end
            S_COST2:
            begin
                t_next = {1'b0, mul_p[63:0]};
                state_next = S_COST3;
            end
            S_COST3:
            begin
                result_next.match_slot = best_idx_reg;
                result_next.world_x = wx_reg;
                result_next.world_y = wy_reg;
                result_next.cost_sum = add_sat(cost_reg, t_reg + {33'd0, mul_p[63:32]});
                result_next.obs_count = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
                result_next.particle_done = obs_reg.final_obs;
                result_valid_next = 1'b1;
                if (obs_reg.final_obs)
                begin
                    cost_next = '0;
                    count_next = '0;
                end
                else
                begin
                    cost_next = result_next.cost_sum;
                    count_next = result_next.obs_count;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg <= '0;
            issue_reg <= '0;
            v1_reg <= 1'b0;
            inv_x_reg <= 32'd65536;
            inv_y_reg <= 32'd65536;
            lm_count_reg <= LM_CW'(1);
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_head_reg <= '0;
            cost_reg <= '0;
            count_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            issue_reg <= issue_next;
            v1_reg <= v1_next;
            cost_reg <= cost_next;
            count_reg <= count_next;
            result_valid_reg <= result_valid_next;
            if (accept && item.command == CMD_POSE)
            begin
                pose_x_reg <= item.coord_x;
                pose_y_reg <= item.coord_y;
                pose_head_reg <= item.heading;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_INV_X: inv_x_reg <= cfg_data;
                    REG_INV_Y: inv_y_reg <= cfg_data;
                    REG_LM_COUNT: lm_count_reg <= cfg_data[LM_CW-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
